/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NBCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/nbct_pkg.sv */
// ----------------------------------------------------------------------------
// nbct_pkg
// Types and constants of the NAT behaviour classifier table.
// ----------------------------------------------------------------------------
package nbct_pkg;

    localparam int TIME_W     = 48;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] KIND_OBSERVE  = 2'd0;
    localparam logic [1:0] KIND_CLASSIFY = 2'd1;
    localparam logic [1:0] KIND_REMOVE   = 2'd2;
    localparam logic [1:0] KIND_PURGE    = 2'd3;

    localparam logic [2:0] NAT_UNKNOWN    = 3'd0;
    localparam logic [2:0] NAT_FULL_CONE  = 3'd1;
    localparam logic [2:0] NAT_RESTRICTED = 3'd2;
    localparam logic [2:0] NAT_PORT_RESTR = 3'd3;
    localparam logic [2:0] NAT_SYMMETRIC  = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_REPORT_STALE_AGE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PURGE_AGE        = 1'd1;

    localparam logic [CFG_DATA_W-1:0] REPORT_STALE_AGE_RST = 32'd5000;
    localparam logic [CFG_DATA_W-1:0] PURGE_AGE_RST        = 32'd30000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       peer_ip;
        logic [31:0]       src_addr;
        logic [15:0]       src_udp_port;
        logic              src_is_v4;
        logic [31:0]       dst_addr;
        logic              dst_is_v4;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0] nat_type;
        logic [3:0] confidence;
        logic       stale;
        logic       accepted;
    } result_t;

    // One window slot: source endpoint and destination.
    typedef struct packed {
        logic        s_v4;
        logic [31:0] s_addr;
        logic [15:0] s_port;
        logic        d_v4;
        logic [31:0] d_addr;
    } obs_t;

    typedef struct packed {
        logic cap;
        logic scan_en;
        logic ld_en;
        logic cls_en;
        logic commit;
        logic fin;
    } nbct_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       obs_ignore;
        logic       scan_done;
        logic       hit;
        logic       win_empty;
        logic       ld_done;
        logic       cls_done;
    } nbct_sts_t;

endpackage

/* rtl/nbct_ctrl.sv */
// ----------------------------------------------------------------------------
// nbct_ctrl
// Sequencer: scan, window load, classify steps, commit and result beat.
// ----------------------------------------------------------------------------
module nbct_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output nbct_pkg::nbct_cmd_t cmd,
    input  nbct_pkg::nbct_sts_t sts
);
    import nbct_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_CLS    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.obs_ignore)
                begin
                    state_next = S_FIN;
                end
                else if (sts.scan_done)
                begin
                    case (sts.kind)
                        KIND_OBSERVE:  state_next = S_COMMIT;
                        KIND_REMOVE:   state_next = S_COMMIT;
                        KIND_CLASSIFY: state_next = (sts.hit && !sts.win_empty) ? S_LOAD : S_FIN;
                        default:       state_next = S_FIN;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.ld_en = 1'b1;
                if (sts.ld_done)
                begin
                    state_next = S_CLS;
                end
            end
            S_CLS:
            begin
                cmd.cls_en = 1'b1;
                if (sts.cls_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

/* rtl/nbct_dp.sv */
// ----------------------------------------------------------------------------
// nbct_dp
// Datapath: peer table, window store, scan, classify and result registers.
// ----------------------------------------------------------------------------
module nbct_dp
#(
    parameter int PEERS  = 64,
    parameter int WINDOW = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  nbct_pkg::item_t                    item,
    input  logic                               cfg_we,
    input  logic [nbct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nbct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  nbct_pkg::nbct_cmd_t                cmd,
    output nbct_pkg::nbct_sts_t                sts,
    output nbct_pkg::result_t                  result
);
    import nbct_pkg::*;

    localparam int PIW = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int PCW = $clog2(PEERS + 1);
    localparam int WIW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WCW = $clog2(WINDOW + 1);
    localparam int OBS_DEPTH = PEERS * WINDOW;
    localparam int OAW = (OBS_DEPTH > 1) ? $clog2(OBS_DEPTH) : 1;

    typedef struct packed {
        logic [31:0]       peer;
        logic [TIME_W-1:0] last;
        logic [WCW-1:0]    cnt;
        logic [WIW-1:0]    head;
    } pent_t;

    function automatic logic [WIW-1:0] wrap_add(input logic [WIW-1:0] a,
                                                input logic [WIW-1:0] b);
        logic [WIW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (WIW+1)'(WINDOW))
        begin
            s = s - (WIW+1)'(WINDOW);
        end
        return s[WIW-1:0];
    endfunction

    // Configuration
    logic [CFG_DATA_W-1:0] stale_age_reg;
    logic [CFG_DATA_W-1:0] purge_age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_age_reg <= REPORT_STALE_AGE_RST;
            purge_age_reg <= PURGE_AGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_REPORT_STALE_AGE: stale_age_reg <= cfg_wdata;
                CFG_PURGE_AGE:        purge_age_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            item_reg <= item;
        end
    end

    // Peer table memory
    pent_t            pmem [PEERS];
    pent_t            prd_reg;
    logic [PIW-1:0]   p_raddr;
    logic             p_we;
    logic [PIW-1:0]   p_waddr;
    pent_t            p_wdata;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        prd_reg <= pmem[p_raddr];
    end

    // Window memory
    obs_t             omem [OBS_DEPTH];
    obs_t             ord_reg;
    logic [OAW-1:0]   o_raddr;
    logic             o_we;
    logic [OAW-1:0]   o_waddr;
    obs_t             o_wdata;

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            omem[o_waddr] <= o_wdata;
        end
        ord_reg <= omem[o_raddr];
    end

    // Table scan
    logic [PCW-1:0]    scan_cnt_reg;
    logic              chk_vld_reg;
    logic [PIW-1:0]    chk_idx_reg;
    logic              scan_issue;
    logic [PEERS-1:0]  valid_reg;
    logic              hit_reg;
    logic [PIW-1:0]    hit_idx_reg;
    pent_t             hit_ent_reg;
    logic              free_reg;
    logic [PIW-1:0]    free_idx_reg;
    logic              chk_v;
    logic [TIME_W-1:0] chk_age;
    logic              purge_clr;

    assign scan_issue = cmd.scan_en && (scan_cnt_reg != PCW'(PEERS));
    assign p_raddr    = scan_cnt_reg[PIW-1:0];
    assign chk_v      = valid_reg[chk_idx_reg];
    assign chk_age    = item_reg.now_ms - prd_reg.last;
    assign purge_clr  = chk_vld_reg && chk_v && (item_reg.kind == KIND_PURGE)
                        && (chk_age > TIME_W'(purge_age_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else if (cmd.cap)
        begin
            scan_cnt_reg <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= scan_issue;
            if (scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (chk_vld_reg && chk_v && !hit_reg && prd_reg.peer == item_reg.peer_ip)
            begin
                hit_reg <= 1'b1;
            end
            if (chk_vld_reg && !chk_v && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= p_raddr;
        if (chk_vld_reg && chk_v && !hit_reg && prd_reg.peer == item_reg.peer_ip)
        begin
            hit_idx_reg <= chk_idx_reg;
            hit_ent_reg <= prd_reg;
        end
        if (chk_vld_reg && !chk_v && !free_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
    end

    // Observe commit
    logic              obs_found;
    logic [PIW-1:0]    tgt_idx;
    logic [WCW-1:0]    n0;
    logic [WIW-1:0]    h0;
    logic [WIW-1:0]    w_slot;
    logic [WCW-1:0]    new_cnt;
    logic [WIW-1:0]    new_head;
    logic              obs_ignore;

    assign obs_ignore = (item_reg.peer_ip == 32'd0) || (item_reg.src_udp_port == 16'd0);
    assign obs_found  = hit_reg || free_reg;
    assign tgt_idx    = hit_reg ? hit_idx_reg : free_idx_reg;
    assign n0         = hit_reg ? hit_ent_reg.cnt : '0;
    assign h0         = hit_reg ? hit_ent_reg.head : '0;

    always_comb
    begin
        if (n0 >= WCW'(WINDOW))
        begin
            w_slot   = h0;
            new_head = wrap_add(h0, WIW'(1));
            new_cnt  = n0;
        end
        else
        begin
            w_slot   = wrap_add(h0, n0[WIW-1:0]);
            new_head = h0;
            new_cnt  = n0 + 1'b1;
        end
    end

    assign p_we         = cmd.commit && (item_reg.kind == KIND_OBSERVE) && !obs_ignore
                          && obs_found;
    assign p_waddr      = tgt_idx;
    assign p_wdata.peer = item_reg.peer_ip;
    assign p_wdata.last = item_reg.now_ms;
    assign p_wdata.cnt  = new_cnt;
    assign p_wdata.head = new_head;

    assign o_we           = p_we;
    assign o_waddr        = OAW'(tgt_idx) * OAW'(WINDOW) + OAW'(w_slot);
    assign o_wdata.s_v4   = item_reg.src_is_v4;
    assign o_wdata.s_addr = item_reg.src_addr;
    assign o_wdata.s_port = item_reg.src_udp_port;
    assign o_wdata.d_v4   = item_reg.dst_is_v4;
    assign o_wdata.d_addr = item_reg.dst_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (purge_clr)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (p_we)
            begin
                valid_reg[tgt_idx] <= 1'b1;
            end
            if (cmd.commit && (item_reg.kind == KIND_REMOVE) && hit_reg)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Window load, oldest slot first
    logic [WCW-1:0] ld_cnt_reg;
    logic           ld_vld_reg;
    logic [WIW-1:0] ld_k_reg;
    logic           ld_issue;
    logic [WIW-1:0] ld_slot;
    obs_t           win_reg [WINDOW];

    assign ld_issue = cmd.ld_en && (ld_cnt_reg != hit_ent_reg.cnt);
    assign ld_slot  = wrap_add(hit_ent_reg.head, ld_cnt_reg[WIW-1:0]);
    assign o_raddr  = OAW'(hit_idx_reg) * OAW'(WINDOW) + OAW'(ld_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_cnt_reg <= '0;
            ld_vld_reg <= 1'b0;
        end
        else if (cmd.cap)
        begin
            ld_cnt_reg <= '0;
            ld_vld_reg <= 1'b0;
        end
        else
        begin
            ld_vld_reg <= ld_issue;
            if (ld_issue)
            begin
                ld_cnt_reg <= ld_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_k_reg <= ld_cnt_reg[WIW-1:0];
        if (ld_vld_reg)
        begin
            win_reg[ld_k_reg] <= ord_reg;
        end
    end

    // Classify: one window slot a step against all older slots
    logic [WCW-1:0] cls_i_reg;
    logic [WCW-1:0] dests_reg;
    logic [WCW-1:0] srcs_reg;
    logic           varies_reg;
    logic           cls_done;
    logic           cls_step;
    obs_t           cur;
    logic           dnew;
    logic           snew;
    logic           vfound;
    logic           vdiff;

    assign cls_done = (cls_i_reg == hit_ent_reg.cnt);
    assign cls_step = cmd.cls_en && !cls_done;
    assign cur      = win_reg[cls_i_reg[WIW-1:0]];

    always_comb
    begin
        dnew   = cur.d_v4;
        snew   = cur.s_v4;
        vfound = 1'b0;
        vdiff  = 1'b0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (WCW'(j) < cls_i_reg)
            begin
                if (cur.d_v4 && win_reg[j].d_v4 && win_reg[j].d_addr == cur.d_addr)
                begin
                    dnew = 1'b0;
                end
                if (cur.s_v4 && win_reg[j].s_v4 && win_reg[j].s_addr == cur.s_addr
                    && win_reg[j].s_port == cur.s_port)
                begin
                    snew = 1'b0;
                end
                if (cur.d_v4 && cur.s_v4 && !vfound && win_reg[j].d_v4
                    && win_reg[j].s_v4 && win_reg[j].d_addr == cur.d_addr)
                begin
                    vfound = 1'b1;
                    vdiff  = (win_reg[j].s_port != cur.s_port);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_i_reg  <= '0;
            dests_reg  <= '0;
            srcs_reg   <= '0;
            varies_reg <= 1'b0;
        end
        else if (cmd.cap)
        begin
            cls_i_reg  <= '0;
            dests_reg  <= '0;
            srcs_reg   <= '0;
            varies_reg <= 1'b0;
        end
        else if (cls_step)
        begin
            cls_i_reg  <= cls_i_reg + 1'b1;
            dests_reg  <= dests_reg + WCW'(dnew);
            srcs_reg   <= srcs_reg + WCW'(snew);
            varies_reg <= varies_reg | vdiff;
        end
    end

    // Result
    result_t           result_reg;
    result_t           result_next;
    logic [TIME_W-1:0] hit_age;

    assign hit_age = item_reg.now_ms - hit_ent_reg.last;

    always_comb
    begin
        result_next = '0;
        case (item_reg.kind)
            KIND_OBSERVE:
            begin
                result_next.accepted = !obs_ignore && obs_found;
            end
            KIND_CLASSIFY:
            begin
                if (!hit_reg || hit_ent_reg.cnt == '0)
                begin
                    result_next.stale = 1'b1;
                end
                else
                begin
                    result_next.stale      = (hit_age > TIME_W'(stale_age_reg));
                    result_next.confidence = 4'(dests_reg);
                    result_next.accepted   = 1'b1;
                    if (srcs_reg == WCW'(1))
                    begin
                        result_next.nat_type = NAT_FULL_CONE;
                    end
                    else if (varies_reg)
                    begin
                        result_next.nat_type = NAT_PORT_RESTR;
                    end
                    else if (srcs_reg > dests_reg)
                    begin
                        result_next.nat_type = NAT_RESTRICTED;
                    end
                    else
                    begin
                        result_next.nat_type = NAT_SYMMETRIC;
                    end
                end
            end
            KIND_REMOVE:
            begin
                result_next.accepted = hit_reg;
            end
            default:
            begin
                result_next.accepted = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    assign sts.kind       = item_reg.kind;
    assign sts.obs_ignore = (item_reg.kind == KIND_OBSERVE) && obs_ignore;
    assign sts.scan_done  = (scan_cnt_reg == PCW'(PEERS)) && !chk_vld_reg;
    assign sts.hit        = hit_reg;
    assign sts.win_empty  = (hit_ent_reg.cnt == '0);
    assign sts.ld_done    = (ld_cnt_reg == hit_ent_reg.cnt) && !ld_vld_reg;
    assign sts.cls_done   = cls_done;

endmodule

/* rtl/nat_behaviour_classifier_table_unit.sv */
// ----------------------------------------------------------------------------
// nat_behaviour_classifier_table_unit
// Peer table with a sliding endpoint window per peer and NAT type classifier.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with a command beat on item; the beat is
//   taken on the edge where start is high and busy is low. busy stays high
//   until the result beat has gone out.
//   Result channel: done is high for exactly one cycle with the result beat
//   on result. The receiver cannot stall it; capture it in that cycle.
//   Config port: cfg_we, cfg_addr, cfg_wdata write report_stale_age (0) or
//   purge_age (1); write only while busy is low.
// Sequence (one command at a time):
//   Every command but an ignored observation walks the peer table through
//   its single read port, one entry a cycle. Observe and remove then commit
//   to the table; purge clears aged entries during the walk. Classify of a
//   known peer with stored observations then loads its window of n entries
//   (n = stored observations, at most WINDOW) and classifies them one at a
//   time. An ignored observation skips the walk.
// Reset: clears all peer valid bits, restores config defaults; the memories
//   need no clearing pass since the contents of invalid entries are never used.
// ----------------------------------------------------------------------------
module nat_behaviour_classifier_table_unit
#(
    parameter int PEERS  = 64,
    parameter int WINDOW = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  nbct_pkg::item_t                 item,
    output logic                            done,
    output nbct_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [nbct_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nbct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nbct_pkg::*;

    nbct_cmd_t cmd;
    nbct_sts_t sts;

    // Sequence each command through scan, load, classify and commit.
    nbct_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Hold table, window store and result registers.
    nbct_dp
    #(
        .PEERS  (PEERS),
        .WINDOW (WINDOW)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

/* rtl/nbct_checker.sv */
// ----------------------------------------------------------------------------
// nbct_checker
// Port-level checks of the command/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nbct_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input nbct_pkg::result_t result
);
    import nbct_pkg::*;

    `NBCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `NBCT_ASSERT_SAME(a_done_busy, done, busy)
    `NBCT_ASSERT_NEXT(a_done_single, done, !done)
    `NBCT_ASSERT_SAME(a_idle_after_done, $fell(busy), $past(done))
    `NBCT_ASSERT_SAME(a_type_range, done, result.nat_type <= NAT_SYMMETRIC)

endmodule

bind nat_behaviour_classifier_table_unit nbct_checker u_nbct_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* tb/nat_behaviour_classifier_table_unit_test.sv */
// ----------------------------------------------------------------------------
// nat_behaviour_classifier_table_unit_test
// Self-checking bench: a queue of command beats feeds a clocked driver, a
// clocked monitor compares every result beat against a software model of the
// peer table, window and classifier kept inside the bench.
// ----------------------------------------------------------------------------
module nat_behaviour_classifier_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import nbct_pkg::*;

    localparam int PEERS  = 64;
    localparam int WINDOW = 8;
    localparam int DRAIN  = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    logic done;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    nat_behaviour_classifier_table_unit #(.PEERS(PEERS), .WINDOW(WINDOW)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state of the peer table.
    logic [31:0] stale_limit;
    logic [31:0] purge_limit;
    bit          pv [PEERS];
    logic [31:0] pip [PEERS];
    logic [47:0] plast [PEERS];
    int          pcnt [PEERS];
    obs_t        pwin [PEERS][WINDOW];

    item_t   pending_cmds[$];
    result_t awaited[$];
    int      sender_idle_pct = 0;
    int      mismatches = 0;

    function automatic int lookup(logic [31:0] ip);
        for (int i = 0; i < PEERS; i++)
            if (pv[i] && pip[i] == ip)
                return i;
        return -1;
    endfunction

    // Derive NAT type and confidence from one peer's window.
    function automatic void grade(int e, output logic [2:0] ty, output logic [3:0] cf);
        int dests, srcs;
        bit varies, dnew, snew;
        obs_t a, b;
        dests = 0;
        srcs = 0;
        varies = 0;
        for (int i = 0; i < pcnt[e]; i++)
        begin
            a = pwin[e][i];
            dnew = a.d_v4;
            snew = a.s_v4;
            for (int j = 0; j < i; j++)
            begin
                b = pwin[e][j];
                if (a.d_v4 && b.d_v4 && b.d_addr == a.d_addr)
                    dnew = 0;
                if (a.s_v4 && b.s_v4 && b.s_addr == a.s_addr && b.s_port == a.s_port)
                    snew = 0;
            end
            dests += dnew;
            srcs += snew;
            if (a.d_v4 && a.s_v4)
                for (int j = 0; j < i; j++)
                begin
                    b = pwin[e][j];
                    if (b.d_v4 && b.s_v4 && b.d_addr == a.d_addr)
                    begin
                        if (b.s_port != a.s_port)
                            varies = 1;
                        break;
                    end
                end
        end
        cf = dests[3:0];
        if (srcs == 1)
            ty = NAT_FULL_CONE;
        else if (varies)
            ty = NAT_PORT_RESTR;
        else if (srcs > dests)
            ty = NAT_RESTRICTED;
        else
            ty = NAT_SYMMETRIC;
    endfunction

    // Apply one command to the model and return the result it should give.
    function automatic result_t table_step(item_t c);
        result_t r;
        int e;
        obs_t o;
        r = '0;
        case (c.kind)
            KIND_OBSERVE:
                if (c.peer_ip != 0 && c.src_udp_port != 0)
                begin
                    e = lookup(c.peer_ip);
                    if (e < 0)
                    begin
                        for (int i = 0; i < PEERS; i++)
                            if (!pv[i])
                            begin
                                e = i;
                                break;
                            end
                        if (e >= 0)
                        begin
                            pv[e] = 1;
                            pip[e] = c.peer_ip;
                            pcnt[e] = 0;
                        end
                    end
                    if (e >= 0)
                    begin
                        plast[e] = c.now_ms;
                        if (pcnt[e] >= WINDOW)
                        begin
                            for (int i = 0; i < WINDOW - 1; i++)
                                pwin[e][i] = pwin[e][i + 1];
                            pcnt[e] = WINDOW - 1;
                        end
                        o.s_v4 = c.src_is_v4;
                        o.s_addr = c.src_addr;
                        o.s_port = c.src_udp_port;
                        o.d_v4 = c.dst_is_v4;
                        o.d_addr = c.dst_addr;
                        pwin[e][pcnt[e]] = o;
                        pcnt[e]++;
                        r.accepted = 1;
                    end
                end
            KIND_CLASSIFY:
            begin
                e = lookup(c.peer_ip);
                if (e < 0 || pcnt[e] == 0)
                    r.stale = 1;
                else
                begin
                    r.stale = (c.now_ms - plast[e]) > {16'd0, stale_limit};
                    grade(e, r.nat_type, r.confidence);
                    r.accepted = 1;
                end
            end
            KIND_REMOVE:
            begin
                e = lookup(c.peer_ip);
                if (e >= 0)
                begin
                    pv[e] = 0;
                    r.accepted = 1;
                end
            end
            default:
            begin
                for (int i = 0; i < PEERS; i++)
                    if (pv[i] && (c.now_ms - plast[i]) > {16'd0, purge_limit})
                        pv[i] = 0;
                r.accepted = 1;
            end
        endcase
        return r;
    endfunction

    // Driver: hold start until the beat is taken, then advance the queue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                awaited.push_back(table_step(item));
                if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                    item <= pending_cmds.pop_front();
                else
                    start <= 1'b0;
            end
            else if (!start && pending_cmds.size() > 0 &&
                     $urandom_range(99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                item <= pending_cmds.pop_front();
            end
        end
    end

    // Monitor: the result beat lives one cycle; compare it with the oldest.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", result);
            end
            else
            begin
                want = awaited.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, result);
                end
            end
        end
    end

    // Near-wrap and ordinary time values.
    function automatic logic [47:0] pick_time();
        case ($urandom_range(3))
            0: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(40000));
            1: return 48'($urandom_range(40000));
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic item_t obs_cmd(logic [31:0] ip, logic [47:0] t);
        item_t c;
        c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom())};
        c.kind = KIND_OBSERVE;
        c.peer_ip = ip;
        c.now_ms = t;
        // Small address pools so sources and destinations repeat.
        if ($urandom_range(3) != 0)
        begin
            c.src_addr = 32'hC0A8_0000 | $urandom_range(2);
            c.dst_addr = 32'h0A00_0000 | $urandom_range(3);
            c.src_udp_port = 16'(16'd1000 + $urandom_range(2));
            c.src_is_v4 = $urandom_range(7) != 0;
            c.dst_is_v4 = $urandom_range(7) != 0;
        end
        if (c.src_udp_port == 0)
            c.src_udp_port = 1;
        return c;
    endfunction

    function automatic item_t op_cmd(logic [1:0] k, logic [31:0] ip, logic [47:0] t);
        item_t c;
        c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 4'($urandom())};
        c.kind = k;
        c.peer_ip = ip;
        c.now_ms = t;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || busy || awaited.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_REPORT_STALE_AGE)
            stale_limit = val;
        else
            purge_limit = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        item_t c;
        logic [31:0] ip;
        logic [47:0] t;
        stale_limit = REPORT_STALE_AGE_RST;
        purge_limit = PURGE_AGE_RST;
        for (int i = 0; i < PEERS; i++)
        begin
            pv[i] = 0;
            pcnt[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored observations, window overflow, classify, remove,
        // absent peer, purge, field extremes.
        t = 48'hFFFF_FFFF_FF00;
        c = obs_cmd(0, t);
        pending_cmds.push_back(c);
        c = obs_cmd(32'hFFFF_FFFF, t);
        c.src_udp_port = 0;
        pending_cmds.push_back(c);
        for (int i = 0; i < 10; i++)
        begin
            c = obs_cmd(32'hFFFF_FFFF, t + i);
            c.src_udp_port = (i == 9) ? 16'hFFFF : 16'd1;
            pending_cmds.push_back(c);
        end
        pending_cmds.push_back(op_cmd(KIND_CLASSIFY, 32'hFFFF_FFFF, t + 300));
        pending_cmds.push_back(op_cmd(KIND_CLASSIFY, 32'hFFFF_FFFF, 48'd6000));
        pending_cmds.push_back(op_cmd(KIND_CLASSIFY, 32'h1234, t));
        pending_cmds.push_back(op_cmd(KIND_REMOVE, 32'hFFFF_FFFF, t));
        pending_cmds.push_back(op_cmd(KIND_REMOVE, 32'hFFFF_FFFF, t));
        c = obs_cmd(32'd5, t);
        c.src_is_v4 = 0;
        pending_cmds.push_back(c);
        pending_cmds.push_back(op_cmd(KIND_CLASSIFY, 32'd5, t));
        pending_cmds.push_back(op_cmd(KIND_PURGE, 0, t + 48'd40000));
        pending_cmds.push_back(op_cmd(KIND_CLASSIFY, 32'd5, t));
        wait_drained();

        // Random phases, sweeping register settings and idle ratios.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 49;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 35;
            endcase
            case (ph)
                1: begin write_reg(CFG_REPORT_STALE_AGE, 0); write_reg(CFG_PURGE_AGE, 0); end
                2: begin
                    write_reg(CFG_REPORT_STALE_AGE, 32'hFFFF_FFFF);
                    write_reg(CFG_PURGE_AGE, 32'hFFFF_FFFF);
                end
                4: begin
                    write_reg(CFG_REPORT_STALE_AGE, $urandom());
                    write_reg(CFG_PURGE_AGE, $urandom());
                end
                5: begin write_reg(CFG_REPORT_STALE_AGE, 100); write_reg(CFG_PURGE_AGE, 2000); end
                default: ;
            endcase
            // Phase 3 fills the table past its capacity.
            for (int n = 0; n < 200; n++)
            begin
                if (ph == 3)
                    ip = 32'h100 + $urandom_range(PEERS + 8);
                else
                    ip = 32'h100 + $urandom_range(12);
                if ($urandom_range(49) == 0)
                    ip = $urandom();
                t = (ph < 4) ? 48'hFFFF_FFFF_F000 + n * 20 : pick_time();
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: c = obs_cmd(ip, t);
                    11, 12, 13, 14, 15: c = op_cmd(KIND_CLASSIFY, ip, t);
                    16, 17: c = op_cmd(KIND_REMOVE, ip, t);
                    18: c = op_cmd(KIND_PURGE, ip, t);
                    default: begin c = obs_cmd(ip, t); c.src_udp_port = 0; end
                endcase
                pending_cmds.push_back(c);
            end
            wait_drained();
        end

        if (mismatches == 0 && awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/nbct_pkg.sv
rtl/nbct_ctrl.sv
rtl/nbct_dp.sv
rtl/nat_behaviour_classifier_table_unit.sv
rtl/nbct_checker.sv
tb/nat_behaviour_classifier_table_unit_test.sv
